// File: rtl/core/sobel_edge_magnitude_core_macros.svh
// assertion macros used by the checker file
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SEM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sem check failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sem check failed");

`endif

// File: rtl/core/sem_pkg.sv
package sem_pkg;

    localparam int SEM_MAX_WIDTH  = 2048;
    localparam int SEM_MAX_HEIGHT = 4096;
    localparam int SEM_CMP_W      = 14;
    localparam int SEM_ROW_W      = 12;
    localparam int SEM_HGT_W      = 13;
    localparam int SEM_WID_W      = 12;
    localparam int SEM_LUMA_W     = 16;
    localparam int SEM_GRAD_W     = 19;
    localparam int SEM_ABS_W      = 18;
    localparam int SEM_RAD_W      = 38;
    localparam int SEM_ROOT_W     = 19;
    localparam int SEM_REM_W      = 21;
    localparam int SEM_ADDR_W     = 4;
    localparam int SEM_DATA_W     = 32;

    localparam logic [7:0] W_RED   = 8'd77;
    localparam logic [7:0] W_GREEN = 8'd150;
    localparam logic [7:0] W_BLUE  = 8'd29;
    localparam logic [SEM_ROOT_W-1:0] FULL_SCALE = 19'd65280;

    typedef enum logic [1:0] {
        REG_INVERT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } sem_reg_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_LOAD,
        FR_PUSH
    } sem_front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQX,
        BK_SQY,
        BK_ROOT,
        BK_DONE
    } sem_back_state_t;

    typedef struct packed {
        logic signed [SEM_GRAD_W-1:0] gx;
        logic signed [SEM_GRAD_W-1:0] gy;
        logic                         last;
    } sem_grad_t;

endpackage

// File: rtl/core/sem_pix_if.sv
interface sem_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/core/sem_res_if.sv
interface sem_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_value;
    logic       last_in_frame;
    modport source (output valid, output edge_value, output last_in_frame, input ready);
    modport sink (input valid, input edge_value, input last_in_frame, output ready);
endinterface

// File: rtl/core/sobel_edge_magnitude_core.sv
// sobel edge magnitude core: raster rgb pixels in, one 8-bit edge value out for every
// interior pixel (not in the first two rows or columns), one row and one column behind.
// the front converts a pixel to 8.8 luma, reads and rewrites the two line stores and
// shifts the 3x3 window: it takes a pixel while idle, loads it, and for an interior
// pixel then pushes the kernel sums, holding until the queue takes them. a two-entry
// queue carries the sums to the back, which takes one pair at a time, squares |gx| and
// |gy| in turn, then runs a one-bit-per-cycle square root for 19 root bits.
// line stores are not cleared; registers: 0 invert, 1 width, 2 height, at 4*index.
module sobel_edge_magnitude_core
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sem_pix_if.sink               pixel,
    sem_res_if.source             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [SEM_ADDR_W-1:0] paddr,
    input  logic [SEM_DATA_W-1:0] pwdata,
    output logic [SEM_DATA_W-1:0] prdata,
    output logic                  pready
);
    // configuration registers
    logic                 invert_reg;
    logic [SEM_WID_W-1:0] width_reg;
    logic [SEM_HGT_W-1:0] height_reg;
    logic                 cfg_write;
    sem_reg_t             reg_sel;

    // request path between front and back
    logic      push_valid, push_ready, pop_valid, pop_ready;
    sem_grad_t push_data, pop_data;

    assign pready    = 1'b1;
    assign reg_sel   = sem_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
            width_reg  <= SEM_WID_W'(640);
            height_reg <= SEM_HGT_W'(480);
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_INVERT: invert_reg <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[SEM_WID_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SEM_HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, unused addresses read zero
    always_comb
    begin
        case (reg_sel)
            REG_INVERT: prdata = SEM_DATA_W'(invert_reg);
            REG_WIDTH:  prdata = SEM_DATA_W'(width_reg);
            REG_HEIGHT: prdata = SEM_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .pixel(pixel),
        .cfg_width(width_reg), .cfg_height(height_reg),
        .push_valid(push_valid), .push_data(push_data), .push_ready(push_ready)
    );

    sem_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(push_valid), .push_data(push_data), .push_ready(push_ready),
        .pop_valid(pop_valid), .pop_data(pop_data), .pop_ready(pop_ready)
    );

    sem_back u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_valid(pop_valid), .pop_data(pop_data), .pop_ready(pop_ready),
        .cfg_invert(invert_reg), .result(result)
    );
endmodule

// File: rtl/core/sem_ram.sv
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/sem_front.sv
module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = SEM_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sem_pix_if.sink              pixel,
    input  logic [SEM_WID_W-1:0] cfg_width,
    input  logic [SEM_HGT_W-1:0] cfg_height,
    output logic                 push_valid,
    output sem_grad_t            push_data,
    input  logic                 push_ready
);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam logic [SEM_CMP_W-1:0] MAXW = SEM_CMP_W'(MAX_WIDTH);
    localparam logic [SEM_HGT_W-1:0] MAXH = SEM_HGT_W'(SEM_MAX_HEIGHT);

    sem_front_state_t state_reg, state_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [SEM_ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]      cur_col_reg;
    logic                  interior_reg, last_reg;
    logic [SEM_LUMA_W-1:0] luma_reg;
    logic [SEM_LUMA_W-1:0] win_reg [9];
    logic [SEM_CMP_W-1:0]  w_eff, col_ext;
    logic [SEM_HGT_W-1:0]  h_eff, row_pre, row_cur;
    logic [COL_W-1:0]      col_cur;
    logic                  wrap_c, accept;
    logic [SEM_LUMA_W-1:0] upper_rd, middle_rd;
    logic [SEM_ABS_W-1:0]  gx_p, gx_n, gy_p, gy_n;

    // width and height saturated into their legal ranges
    always_comb
    begin
        w_eff = SEM_CMP_W'(cfg_width);
        if (w_eff < SEM_CMP_W'(3)) w_eff = SEM_CMP_W'(3);
        else if (w_eff > MAXW) w_eff = MAXW;
        h_eff = cfg_height;
        if (h_eff < SEM_HGT_W'(3)) h_eff = SEM_HGT_W'(3);
        else if (h_eff > MAXH) h_eff = MAXH;
    end

    // position of the arriving pixel, allowing for a shrunk frame
    always_comb
    begin
        col_ext = SEM_CMP_W'(col_reg);
        wrap_c  = col_ext >= w_eff;
        row_pre = wrap_c ? SEM_HGT_W'(row_reg) + 1'b1 : SEM_HGT_W'(row_reg);
        row_cur = (row_pre >= h_eff) ? '0 : row_pre;
        col_cur = wrap_c ? '0 : col_reg;
        if (SEM_CMP_W'(col_cur) + 1'b1 >= w_eff)
        begin
            col_next = '0;
            row_next = (row_cur + 1'b1 >= h_eff) ? '0 : SEM_ROW_W'(row_cur + 1'b1);
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = SEM_ROW_W'(row_cur);
        end
    end

    assign pixel.ready = (state_reg == FR_IDLE);
    assign accept      = pixel.valid && pixel.ready;

    sem_ram #(.WIDTH(SEM_LUMA_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(state_reg == FR_LOAD), .waddr(cur_col_reg), .wdata(middle_rd),
        .raddr(col_cur), .rdata(upper_rd)
    );
    sem_ram #(.WIDTH(SEM_LUMA_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk(clk), .we(state_reg == FR_LOAD), .waddr(cur_col_reg), .wdata(luma_reg),
        .raddr(col_cur), .rdata(middle_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: if (accept) state_next = FR_LOAD;
            FR_LOAD: state_next = interior_reg ? FR_PUSH : FR_IDLE;
            FR_PUSH: if (push_ready) state_next = FR_IDLE;
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (state_reg == FR_LOAD)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= upper_rd;
                win_reg[5] <= middle_rd;
                win_reg[8] <= luma_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_col_reg  <= col_cur;
            interior_reg <= (row_cur >= SEM_HGT_W'(2)) && (col_cur >= COL_W'(2));
            last_reg     <= (row_cur == h_eff - 1'b1) && (SEM_CMP_W'(col_cur) == w_eff - 1'b1);
            luma_reg     <= SEM_LUMA_W'(W_RED * pixel.red) + SEM_LUMA_W'(W_GREEN * pixel.green)
                          + SEM_LUMA_W'(W_BLUE * pixel.blue);
        end
    end

    // sobel kernels over the settled window
    always_comb
    begin
        gx_p = SEM_ABS_W'(win_reg[2]) + {win_reg[5], 1'b0} + SEM_ABS_W'(win_reg[8]);
        gx_n = SEM_ABS_W'(win_reg[0]) + {win_reg[3], 1'b0} + SEM_ABS_W'(win_reg[6]);
        gy_p = SEM_ABS_W'(win_reg[6]) + {win_reg[7], 1'b0} + SEM_ABS_W'(win_reg[8]);
        gy_n = SEM_ABS_W'(win_reg[0]) + {win_reg[1], 1'b0} + SEM_ABS_W'(win_reg[2]);
        push_data.gx   = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
        push_data.gy   = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
        push_data.last = last_reg;
    end

    assign push_valid = (state_reg == FR_PUSH);
endmodule

// File: rtl/core/sem_queue.sv
module sem_queue
    import sem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  sem_grad_t push_data,
    output logic      push_ready,
    output logic      pop_valid,
    output sem_grad_t pop_data,
    input  logic      pop_ready
);
    sem_grad_t  entry_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= ~wptr_reg;
            if (do_pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) entry_reg[wptr_reg] <= push_data;
    end
endmodule

// File: rtl/core/sem_back.sv
module sem_back
    import sem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    input  sem_grad_t pop_data,
    output logic      pop_ready,
    input  logic      cfg_invert,
    sem_res_if.source result
);
    sem_back_state_t state_reg, state_next;
    logic [SEM_ABS_W-1:0]  ax_reg, ay_reg;
    logic                  last_reg;
    logic [SEM_RAD_W-1:0]  rad_reg;
    logic [SEM_REM_W-1:0]  rem_reg;
    logic [SEM_ROOT_W-1:0] root_reg;
    logic [4:0]            cnt_reg;
    logic                  rvalid_reg;
    logic [7:0]            redge_reg;
    logic                  rlast_reg;
    logic [SEM_REM_W+1:0]  rem_sh, trial;
    logic [SEM_ROOT_W-1:0] m_clamp, m_fin;
    logic                  load_out;

    assign pop_ready = (state_reg == BK_IDLE);
    assign load_out  = (state_reg == BK_DONE) && (!rvalid_reg || result.ready);

    // one result bit per step of the restoring square root
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[SEM_RAD_W-1 -: 2]};
        trial  = (SEM_REM_W+2)'({root_reg, 2'b01});
        m_clamp = (root_reg > FULL_SCALE) ? FULL_SCALE : root_reg;
        m_fin   = cfg_invert ? FULL_SCALE - m_clamp : m_clamp;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (pop_valid) state_next = BK_SQX;
            BK_SQX:  state_next = BK_SQY;
            BK_SQY:  state_next = BK_ROOT;
            BK_ROOT: if (cnt_reg == 5'(SEM_ROOT_W - 1)) state_next = BK_DONE;
            BK_DONE: if (load_out) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out) rvalid_reg <= 1'b1;
            else if (result.ready) rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                ax_reg   <= SEM_ABS_W'(pop_data.gx < 0 ? -pop_data.gx : pop_data.gx);
                ay_reg   <= SEM_ABS_W'(pop_data.gy < 0 ? -pop_data.gy : pop_data.gy);
                last_reg <= pop_data.last;
            end
            BK_SQX:
            begin
                rad_reg <= SEM_RAD_W'(ax_reg * ax_reg);
            end
            BK_SQY:
            begin
                rad_reg  <= rad_reg + SEM_RAD_W'(ay_reg * ay_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            BK_ROOT:
            begin
                rad_reg <= {rad_reg[SEM_RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= SEM_REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[SEM_ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= SEM_REM_W'(rem_sh);
                    root_reg <= {root_reg[SEM_ROOT_W-2:0], 1'b0};
                end
            end
            BK_DONE:
            begin
                if (load_out)
                begin
                    redge_reg <= m_fin[15:8];
                    rlast_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign result.valid         = rvalid_reg;
    assign result.edge_value    = redge_reg;
    assign result.last_in_frame = rlast_reg;
endmodule

// File: rtl/core/sem_checker.sv
`include "sobel_edge_magnitude_core_macros.svh"

module sem_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] result_edge,
    input logic       pready
);
    `SEM_ASSERT_NOW(a_pready_high, 1'b1, pready)
    `SEM_ASSERT_NEXT(a_front_busy_after_accept, pixel_valid && pixel_ready, !pixel_ready)
    `SEM_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_edge))
endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .clk(clk), .rst_n(rst_n),
    .pixel_valid(pixel.valid), .pixel_ready(pixel.ready),
    .result_valid(result.valid), .result_ready(result.ready),
    .result_edge(result.edge_value), .pready(pready)
);
